@@ hdl/ppls_pkg.sv @@
// Package for the Phong point light shader: payload types, constants and table functions.
`default_nettype none

package ppls_pkg;

    // Interpolation tables for log2 and exp2 hold 2^LOG_TABLE_BITS + 1 entries.
    localparam int LOG_TABLE_BITS = 8;
    localparam int TBL_N          = 1 << LOG_TABLE_BITS;
    localparam int FRAC_SH        = 30 - LOG_TABLE_BITS;
    localparam int EXP_SH         = 16 - LOG_TABLE_BITS;

    // Iteration counts of the square root and reciprocal pipelines.
    localparam int SQRT_STEPS = 26;
    localparam int DIV_STEPS  = 25;

    // Stage numbering of the valid chain.
    localparam int ST_SQRT_LAST = 4 + SQRT_STEPS;
    localparam int ST_DIV_LAST  = ST_SQRT_LAST + DIV_STEPS;
    localparam int NUM_STAGES   = ST_DIV_LAST + 1 + 5 + 8 + 3;

    localparam logic [34:0] FACTOR_CAP = 35'h4_0000_0000;

    typedef enum logic [2:0] {
        REG_MATERIAL_COLOR   = 3'd0,
        REG_MATERIAL_FACTORS = 3'd1,
        REG_SHININESS        = 3'd2,
        REG_LIGHT_INTENSITY  = 3'd3,
        REG_LIGHT_X          = 3'd4,
        REG_LIGHT_Y          = 3'd5,
        REG_LIGHT_Z          = 3'd6
    } reg_index_t;

    localparam logic [1:0] TERMS_AMBIENT = 2'd0;
    localparam logic [1:0] TERMS_DIFFUSE = 2'd1;
    localparam logic [1:0] TERMS_ALL     = 2'd2;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
        logic signed [15:0] eye_x;
        logic signed [15:0] eye_y;
        logic signed [15:0] eye_z;
        logic               shadowed;
    } hit_t;

    typedef struct packed {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic [1:0]  terms_used;
    } color_t;

    // Geometry that rides along the normalization pipeline.
    typedef struct packed {
        logic             live;
        logic [2:0]       neg;
        logic [2:0][14:0] mag;
        logic [2:0][15:0] nrm;
        logic [2:0][15:0] eye;
    } geo_t;

    typedef struct packed {
        geo_t        g;
        logic [51:0] rad;
        logic [52:0] root;
    } sqrt_t;

    typedef struct packed {
        geo_t        g;
        logic [25:0] q;
        logic [48:0] rem;
        logic [24:0] quot;
    } div_t;

    typedef struct packed {
        logic             live;
        logic [1:0]       terms;
        logic [2:0][17:0] l;
        logic [2:0][15:0] nrm;
        logic [2:0][15:0] eye;
        logic [35:0]      ndl;
        logic [17:0]      ndl14;
        logic [2:0][21:0] tw;
        logic [2:0][22:0] r;
        logic [40:0]      rde;
    } shade_t;

    typedef struct packed {
        logic [1:0]                terms;
        logic [17:0]               ndl14;
        logic [40:0]               x;
        logic [5:0]                p;
        logic [LOG_TABLE_BITS-1:0] kidx;
        logic [FRAC_SH-1:0]        frac;
        logic [16:0]               lk;
        logic [16:0]               lk1;
        logic [22:0]               lg;
        logic [31:0]               t;
        logic [15:0]               ip;
        logic [EXP_SH-1:0]         efrac;
        logic [31:0]               ek;
        logic [31:0]               ek1;
        logic [31:0]               mant;
        logic [34:0]               factor;
    } pow_t;

    typedef struct packed {
        logic [1:0]       terms;
        logic [2:0][17:0] eff;
        logic [19:0]      sd;
        logic [36:0]      ss;
        logic [2:0][19:0] at;
        logic [2:0][23:0] dt;
        logic [2:0][38:0] st;
    } fin_t;

    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] b;
        v   = v_in;
        res = '0;
        b   = 64'h1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v   = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic logic [5:0] msb41(input logic [40:0] x);
        logic [5:0] r;
        r = '0;
        for (int i = 0; i < 41; i++) begin
            if (x[i]) r = 6'(i);
        end
        return r;
    endfunction

    // log2 of 1 + k/TBL_N by repeated squaring, Q.16.
    function automatic logic [16:0] log_entry(input int k);
        logic [63:0] y;
        logic [16:0] res;
        res = '0;
        y   = (64'h1 << 30) + (64'(k) << FRAC_SH);
        if (k == TBL_N) return 17'd65536;
        for (int i = 15; i >= 0; i--) begin
            y = (y * y) >> 30;
            if (y >= 64'h8000_0000) begin
                res[i] = 1'b1;
                y      = y >> 1;
            end
        end
        return res;
    endfunction

    // 2^(k/TBL_N) in Q2.30 as a product of repeated square roots of two.
    function automatic logic [31:0] exp_entry(input int k);
        logic [63:0] root [17];
        logic [63:0] f16;
        logic [63:0] prod;
        root[0] = 64'h1 << 31;
        for (int j = 1; j <= 16; j++) root[j] = isqrt64(root[j-1] << 30);
        f16  = 64'(k) << EXP_SH;
        prod = 64'h1 << 30;
        if (k == TBL_N) return 32'h8000_0000;
        for (int j = 1; j <= 16; j++) begin
            if (f16[16-j]) prod = (prod * root[j]) >> 30;
        end
        return prod[31:0];
    endfunction

endpackage

`default_nettype wire

@@ hdl/phong_point_light_shader_unit.sv @@
// Top level of the Phong point light shader: a single deep pipeline from hit to color.
// Throughput: one transaction per clock while a valid result on color is not stalled.
// A stall on a valid color freezes every stage at once, so hit is stalled in the same cycle.
// Reset clears all valid bits and loads the default material and light registers.
// The log2 and exp2 tables are constants; no memory needs a clearing pass.
`default_nettype none

module phong_point_light_shader_unit
    import ppls_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        hit_valid,
    output logic             hit_stall,
    input  wire hit_t        hit,
    output logic             color_valid,
    input  wire logic        color_stall,
    output color_t           color,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [47:0] cfg_data
);

    // Configuration registers. The user must let them change only while the pipeline is empty;
    // the block does not enforce it. Every stage reads them directly instead of carrying a copy.
    logic [47:0]      material_color_reg;
    logic [47:0]      material_factors_reg;
    logic [15:0]      shininess_reg;
    logic [47:0]      light_intensity_reg;
    logic [2:0][31:0] light_pos_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            material_color_reg   <= 48'h4000_4000_4000;
            material_factors_reg <= 48'h0666_399A_399A;
            shininess_reg        <= 16'hC800;
            light_intensity_reg  <= 48'h4000_4000_4000;
            light_pos_reg        <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_MATERIAL_COLOR:   material_color_reg   <= cfg_data;
                REG_MATERIAL_FACTORS: material_factors_reg <= cfg_data;
                REG_SHININESS:        shininess_reg        <= cfg_data[15:0];
                REG_LIGHT_INTENSITY:  light_intensity_reg  <= cfg_data;
                REG_LIGHT_X:          light_pos_reg[0]     <= cfg_data[31:0];
                REG_LIGHT_Y:          light_pos_reg[1]     <= cfg_data[31:0];
                REG_LIGHT_Z:          light_pos_reg[2]     <= cfg_data[31:0];
                default:              ;
            endcase
        end
    end

    // The whole pipeline advances together unless the finished result is held back.
    logic                  adv;
    logic [NUM_STAGES-1:0] vld_reg;

    assign adv       = !(vld_reg[NUM_STAGES-1] && color_stall);
    assign hit_stall = !adv;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[NUM_STAGES-2:0], hit_valid};
        end
    end

    // Constant tables for the power computation.
    logic [16:0] log_rom [TBL_N+1];
    logic [31:0] exp_rom [TBL_N+1];

    for (genvar g = 0; g <= TBL_N; g++) begin : g_rom
        assign log_rom[g] = log_entry(g);
        assign exp_rom[g] = exp_entry(g);
    end

    // Stage 1: input register.
    hit_t hit_reg;

    always_ff @(posedge clk) begin
        if (adv) hit_reg <= hit;
    end

    // Stage 2: light vector and its component magnitudes.
    logic [2:0][32:0] mag2_reg, mag2_next;
    logic [2:0]       neg2_reg, neg2_next;
    logic [2:0][15:0] nrm2_reg, eye2_reg;
    logic             shd2_reg;
    logic [2:0][31:0] hit_pos;

    assign hit_pos[0] = hit_reg.point_x;
    assign hit_pos[1] = hit_reg.point_y;
    assign hit_pos[2] = hit_reg.point_z;

    always_comb begin
        logic signed [32:0] d;
        for (int i = 0; i < 3; i++) begin
            d = $signed({light_pos_reg[i][31], light_pos_reg[i]})
              - $signed({hit_pos[i][31], hit_pos[i]});
            neg2_next[i] = d[32];
            mag2_next[i] = d[32] ? 33'(-d) : 33'(d);
        end
    end

    always_ff @(posedge clk) begin
        if (adv) begin
            mag2_reg <= mag2_next;
            neg2_reg <= neg2_next;
            nrm2_reg <= {hit_reg.normal_z, hit_reg.normal_y, hit_reg.normal_x};
            eye2_reg <= {hit_reg.eye_z, hit_reg.eye_y, hit_reg.eye_x};
            shd2_reg <= hit_reg.shadowed;
        end
    end

    // Stage 3: largest magnitude and its leading one.
    logic [2:0][32:0] mag3_reg;
    logic [2:0]       neg3_reg;
    logic [2:0][15:0] nrm3_reg, eye3_reg;
    logic             live3_reg, live3_next;
    logic [5:0]       p3_reg, p3_next;

    always_comb begin
        logic [32:0] mx;
        mx = mag2_reg[0];
        if (mag2_reg[1] > mx) mx = mag2_reg[1];
        if (mag2_reg[2] > mx) mx = mag2_reg[2];
        p3_next    = msb41({8'b0, mx});
        live3_next = (mx != 33'd0) && !shd2_reg;
    end

    always_ff @(posedge clk) begin
        if (adv) begin
            mag3_reg  <= mag2_reg;
            neg3_reg  <= neg2_reg;
            nrm3_reg  <= nrm2_reg;
            eye3_reg  <= eye2_reg;
            live3_reg <= live3_next;
            p3_reg    <= p3_next;
        end
    end

    // Stage 4: scale so that the largest magnitude has its top bit at bit 14.
    geo_t geo4_reg, geo4_next;

    always_comb begin
        logic [32:0] sv;
        geo4_next.live = live3_reg;
        geo4_next.neg  = neg3_reg;
        geo4_next.nrm  = nrm3_reg;
        geo4_next.eye  = eye3_reg;
        for (int i = 0; i < 3; i++) begin
            if (p3_reg > 6'd14) sv = mag3_reg[i] >> (p3_reg - 6'd14);
            else                sv = mag3_reg[i] << (6'd14 - p3_reg);
            geo4_next.mag[i] = sv[14:0];
        end
    end

    always_ff @(posedge clk) begin
        if (adv) geo4_reg <= geo4_next;
    end

    // Stage 5 and the square root chain: one result bit per stage.
    sqrt_t sq_reg [SQRT_STEPS+1];
    sqrt_t sq0_next;

    always_comb begin
        logic [31:0] s;
        s = '0;
        for (int i = 0; i < 3; i++) begin
            s = s + 32'(30'(geo4_reg.mag[i]) * 30'(geo4_reg.mag[i]));
        end
        sq0_next.g    = geo4_reg;
        sq0_next.rad  = {s, 20'b0};
        sq0_next.root = '0;
    end

    always_ff @(posedge clk) begin
        if (adv) sq_reg[0] <= sq0_next;
    end

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
        localparam logic [52:0] STEP_BIT = 53'(1) << (2 * (SQRT_STEPS - 1 - k));
        sqrt_t       step_next;
        logic [52:0] trial;

        always_comb begin
            step_next = sq_reg[k];
            trial     = sq_reg[k].root + STEP_BIT;
            if ({1'b0, sq_reg[k].rad} >= trial) begin
                step_next.rad  = sq_reg[k].rad - trial[51:0];
                step_next.root = (sq_reg[k].root >> 1) + STEP_BIT;
            end else begin
                step_next.root = sq_reg[k].root >> 1;
            end
        end

        always_ff @(posedge clk) begin
            if (adv) sq_reg[k+1] <= step_next;
        end
    end

    // Reciprocal chain: 2^48 / root, one quotient bit per stage.
    div_t dv_reg [DIV_STEPS];
    div_t dv_in  [DIV_STEPS];

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        localparam int SH = DIV_STEPS - 1 - k;
        div_t        step_next;
        logic [50:0] dq;

        if (k == 0) begin : g_first
            always_comb begin
                dv_in[k].g    = sq_reg[SQRT_STEPS].g;
                dv_in[k].q    = sq_reg[SQRT_STEPS].root[25:0];
                dv_in[k].rem  = 49'h1 << 48;
                dv_in[k].quot = '0;
            end
        end else begin : g_next
            assign dv_in[k] = dv_reg[k-1];
        end

        always_comb begin
            step_next = dv_in[k];
            dq        = 51'(dv_in[k].q) << SH;
            if ({2'b0, dv_in[k].rem} >= dq) begin
                step_next.rem      = dv_in[k].rem - dq[48:0];
                step_next.quot[SH] = 1'b1;
            end
        end

        always_ff @(posedge clk) begin
            if (adv) dv_reg[k] <= step_next;
        end
    end

    // Shading geometry: unit light vector, n.l, reflection and r.e.
    shade_t sh_reg [5];
    shade_t sh_next [5];

    always_comb begin
        logic [24:0] rinv;
        logic [40:0] u;
        logic [17:0] uu;
        rinv       = dv_reg[DIV_STEPS-1].quot;
        sh_next[0] = '0;
        sh_next[0].live = dv_reg[DIV_STEPS-1].g.live;
        sh_next[0].nrm  = dv_reg[DIV_STEPS-1].g.nrm;
        sh_next[0].eye  = dv_reg[DIV_STEPS-1].g.eye;
        for (int i = 0; i < 3; i++) begin
            u  = 41'(dv_reg[DIV_STEPS-1].g.mag[i]) * 41'(rinv) + (41'(1) << 23);
            uu = {1'b0, u[40:24]};
            sh_next[0].l[i] = dv_reg[DIV_STEPS-1].g.neg[i] ? 18'(-uu) : uu;
        end
    end

    always_comb begin
        logic signed [35:0] acc;
        acc = '0;
        for (int i = 0; i < 3; i++) begin
            acc = acc + $signed(sh_reg[0].l[i]) * $signed(sh_reg[0].nrm[i]);
        end
        sh_next[1]     = sh_reg[0];
        sh_next[1].ndl = acc;
    end

    always_comb begin
        logic signed [35:0] m;
        sh_next[2] = sh_reg[1];
        if (sh_reg[1].live && !sh_reg[1].ndl[35]) begin
            sh_next[2].terms = TERMS_DIFFUSE;
            sh_next[2].ndl14 = sh_reg[1].ndl[31:14];
        end else begin
            sh_next[2].terms = TERMS_AMBIENT;
            sh_next[2].ndl14 = '0;
        end
        for (int i = 0; i < 3; i++) begin
            m = $signed({1'b0, sh_next[2].ndl14, 1'b0}) * $signed(sh_reg[1].nrm[i]);
            m = m >>> 14;
            sh_next[2].tw[i] = m[21:0];
        end
    end

    always_comb begin
        logic signed [22:0] rr;
        sh_next[3] = sh_reg[2];
        for (int i = 0; i < 3; i++) begin
            rr = $signed(sh_reg[2].tw[i]) - $signed(sh_reg[2].l[i]);
            sh_next[3].r[i] = rr;
        end
    end

    always_comb begin
        logic signed [40:0] acc;
        acc = '0;
        for (int i = 0; i < 3; i++) begin
            acc = acc + $signed(sh_reg[3].r[i]) * $signed(sh_reg[3].eye[i]);
        end
        sh_next[4]     = sh_reg[3];
        sh_next[4].rde = acc;
        if (sh_reg[3].terms == TERMS_DIFFUSE && !acc[40] && acc != 41'sd0) begin
            sh_next[4].terms = TERMS_ALL;
        end
    end

    always_ff @(posedge clk) begin
        if (adv) begin
            for (int j = 0; j < 5; j++) sh_reg[j] <= sh_next[j];
        end
    end

    // Power pipeline: (r.e)^shininess through table log2 and exp2.
    pow_t pw_reg [8];
    pow_t pw_next [8];

    always_comb begin
        logic [40:0]               y;
        logic [29:0]               f30;
        logic [LOG_TABLE_BITS:0]   ki;
        logic [38:0]               pi;
        logic signed [6:0]         pe;
        logic signed [39:0]        tm;
        logic [LOG_TABLE_BITS:0]   ke;
        logic [32+EXP_SH-1:0]      pd;
        logic [35:0]               wide;
        logic [15:0]               shr;

        pw_next[0]       = '0;
        pw_next[0].terms = sh_reg[4].terms;
        pw_next[0].ndl14 = sh_reg[4].ndl14;
        pw_next[0].x     = sh_reg[4].rde;
        pw_next[0].p     = msb41(sh_reg[4].rde);

        pw_next[1]      = pw_reg[0];
        y               = pw_reg[0].x << (6'd40 - pw_reg[0].p);
        f30             = y[39:10];
        pw_next[1].kidx = f30[29:FRAC_SH];
        pw_next[1].frac = f30[FRAC_SH-1:0];

        pw_next[2]     = pw_reg[1];
        ki             = {1'b0, pw_reg[1].kidx};
        pw_next[2].lk  = log_rom[ki];
        pw_next[2].lk1 = log_rom[ki + 1'b1];

        pw_next[3]    = pw_reg[2];
        pi            = 39'(pw_reg[2].lk1 - pw_reg[2].lk) * 39'(pw_reg[2].frac);
        pe            = $signed({1'b0, pw_reg[2].p}) - 7'sd28;
        pw_next[3].lg = {pe, 16'b0} + {6'b0, pw_reg[2].lk} + {6'b0, 17'(pi >> FRAC_SH)};

        pw_next[4]   = pw_reg[3];
        tm           = $signed(pw_reg[3].lg) * $signed({1'b0, shininess_reg});
        tm           = tm >>> 8;
        pw_next[4].t = tm[31:0];

        pw_next[5]       = pw_reg[4];
        pw_next[5].ip    = pw_reg[4].t[31:16];
        ke               = {1'b0, pw_reg[4].t[15:EXP_SH]};
        pw_next[5].efrac = pw_reg[4].t[EXP_SH-1:0];
        pw_next[5].ek    = exp_rom[ke];
        pw_next[5].ek1   = exp_rom[ke + 1'b1];

        pw_next[6]      = pw_reg[5];
        pd              = (32+EXP_SH)'(pw_reg[5].ek1 - pw_reg[5].ek)
                        * (32+EXP_SH)'(pw_reg[5].efrac);
        pw_next[6].mant = pw_reg[5].ek + 32'(pd >> EXP_SH);

        // Place the mantissa by the integer part of the exponent, capped at 2^34.
        pw_next[7] = pw_reg[6];
        wide       = '0;
        shr        = 16'd16 - pw_reg[6].ip;
        if ($signed(pw_reg[6].ip) > 16'sd20) begin
            pw_next[7].factor = FACTOR_CAP;
        end else if ($signed(pw_reg[6].ip) >= 16'sd16) begin
            wide = 36'(pw_reg[6].mant) << 3'(pw_reg[6].ip - 16'd16);
            pw_next[7].factor = (wide > 36'(FACTOR_CAP)) ? FACTOR_CAP : wide[34:0];
        end else if ($signed(pw_reg[6].ip) < -16'sd16) begin
            pw_next[7].factor = '0;
        end else begin
            pw_next[7].factor = 35'(pw_reg[6].mant >> shr[5:0]);
        end
    end

    always_ff @(posedge clk) begin
        if (adv) begin
            for (int j = 0; j < 8; j++) pw_reg[j] <= pw_next[j];
        end
    end

    // Color stages: effective color, the three terms, then the saturating sum.
    fin_t   fn_reg [2];
    fin_t   fn_next [2];
    color_t color_reg, color_next;

    always_comb begin
        logic [15:0] mc;
        logic [15:0] ic;
        logic [31:0] me;
        logic [33:0] pk;
        logic [50:0] ps;
        logic [33:0] pa;
        logic [37:0] pdf;
        logic [52:0] pst;
        logic [39:0] sum;
        logic [15:0] chan [3];

        fn_next[0]       = '0;
        fn_next[0].terms = pw_reg[7].terms;
        pk               = 34'(material_factors_reg[31:16]) * 34'(pw_reg[7].ndl14);
        fn_next[0].sd    = pk[33:14];
        ps               = 51'(material_factors_reg[15:0]) * 51'(pw_reg[7].factor);
        fn_next[0].ss    = ps[50:14];
        for (int c = 0; c < 3; c++) begin
            mc = material_color_reg[47-16*c -: 16];
            ic = light_intensity_reg[47-16*c -: 16];
            me = 32'(mc) * 32'(ic);
            fn_next[0].eff[c] = me[31:14];
        end

        fn_next[1] = fn_reg[0];
        for (int c = 0; c < 3; c++) begin
            ic  = light_intensity_reg[47-16*c -: 16];
            pa  = 34'(fn_reg[0].eff[c]) * 34'(material_factors_reg[47:32]);
            pdf = 38'(fn_reg[0].eff[c]) * 38'(fn_reg[0].sd);
            pst = 53'(ic) * 53'(fn_reg[0].ss);
            fn_next[1].at[c] = pa[33:14];
            fn_next[1].dt[c] = (fn_reg[0].terms != TERMS_AMBIENT) ? pdf[37:14] : '0;
            fn_next[1].st[c] = (fn_reg[0].terms == TERMS_ALL) ? pst[52:14] : '0;
        end

        for (int c = 0; c < 3; c++) begin
            sum = 40'(fn_reg[1].at[c]) + 40'(fn_reg[1].dt[c]) + 40'(fn_reg[1].st[c]);
            chan[c] = (sum > 40'hFFFF) ? 16'hFFFF : sum[15:0];
        end
        color_next.red        = chan[0];
        color_next.green      = chan[1];
        color_next.blue       = chan[2];
        color_next.terms_used = fn_reg[1].terms;
    end

    always_ff @(posedge clk) begin
        if (adv) begin
            fn_reg[0] <= fn_next[0];
            fn_reg[1] <= fn_next[1];
            color_reg <= color_next;
        end
    end

    assign color_valid = vld_reg[NUM_STAGES-1];
    assign color       = color_reg;

    // A lit item always yields a root in the range that normalization guarantees.
    assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[ST_SQRT_LAST] && sq_reg[SQRT_STEPS].g.live |->
            sq_reg[SQRT_STEPS].root >= (53'(1) << 24) &&
            sq_reg[SQRT_STEPS].root <  (53'(1) << 26))
        else $error("square root out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[ST_DIV_LAST] && dv_reg[DIV_STEPS-1].g.live |->
            dv_reg[DIV_STEPS-1].quot > (25'(1) << 22) &&
            dv_reg[DIV_STEPS-1].quot <= (25'(1) << 24))
        else $error("reciprocal out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        color_valid && color_stall |-> hit_stall)
        else $error("input taken while the result is held");

    assert property (@(posedge clk) disable iff (!rst_n)
        color_valid |-> color.terms_used != 2'd3)
        else $error("invalid term code");

endmodule

`default_nettype wire

@@ bench/phong_point_light_shader_unit_tb.sv @@
// Self-checking testbench for the Phong point light shader: directed table, then random phases.
`timescale 1ns / 1ps

module phong_point_light_shader_unit_tb;
    import ppls_pkg::*;

    // The run is cut off here.
    localparam int CYCLE_LIMIT = 500000;
    // Idle time before a register write and at the end.
    localparam int SETTLE_CYCLES = 90;
    localparam int NUM_PHASES = 9;
    localparam int ITEMS_PER_PHASE = 170;
    localparam int NUM_ROWS = 12;

    logic        clk;
    logic        rst_n;
    logic        hit_valid;
    logic        hit_stall;
    hit_t        hit;
    logic        color_valid;
    logic        color_stall;
    color_t      color;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [47:0] cfg_data;

    phong_point_light_shader_unit i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .hit_valid   (hit_valid),
        .hit_stall   (hit_stall),
        .hit         (hit),
        .color_valid (color_valid),
        .color_stall (color_stall),
        .color       (color),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Shadow copy of the block's registers, updated whenever the bench writes one.
    logic [47:0]        mat_color;
    logic [47:0]        mat_factors;
    logic [15:0]        shine;
    logic [47:0]        intensity;
    logic signed [31:0] light_pos [3];

    // log2 and exp2 interpolation tables of the predictor.
    longint unsigned log2_tab [TBL_N+1];
    longint unsigned exp2_tab [TBL_N+1];

    color_t pending_colors [$];
    int     errors;
    int     colors_seen;
    int     cycles;
    bit     tx_burst;
    bit     rx_burst;

    typedef struct {
        hit_t   h;
        bit     known;
        color_t c;
    } stim_row_t;

    stim_row_t rows [NUM_ROWS];

    function automatic longint unsigned int_sqrt(input longint unsigned v_in);
        longint unsigned v;
        longint unsigned res;
        longint unsigned b;
        v   = v_in;
        res = 0;
        b   = 64'h1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v   = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic int top_bit(input longint unsigned v);
        int p;
        p = -1;
        for (int i = 0; i < 64; i++)
            if (v[i])
                p = i;
        return p;
    endfunction

    // Tables are filled the way the hardware's constants are defined: log2 by repeated
    // squaring of the mantissa, exp2 as products of repeated square roots of two.
    task automatic fill_tables();
        longint unsigned root [17];
        longint unsigned y;
        longint unsigned prod;
        longint unsigned f16;
        longint unsigned lg;
        root[0] = 64'h1 << 31;
        for (int j = 1; j <= 16; j++)
            root[j] = int_sqrt(root[j-1] << 30);
        for (int k = 0; k <= TBL_N; k++)
        begin
            if (k == TBL_N)
            begin
                log2_tab[k] = 65536;
                exp2_tab[k] = 64'h1 << 31;
            end
            else
            begin
                y  = (64'h1 << 30) + (longint'(k) << FRAC_SH);
                lg = 0;
                for (int i = 15; i >= 0; i--)
                begin
                    y = (y * y) >> 30;
                    if (y >= (64'h1 << 31))
                    begin
                        lg[i] = 1'b1;
                        y = y >> 1;
                    end
                end
                log2_tab[k] = lg;
                f16  = longint'(k) << EXP_SH;
                prod = 64'h1 << 30;
                for (int j = 1; j <= 16; j++)
                    if (f16[16-j])
                        prod = (prod * root[j]) >> 30;
                exp2_tab[k] = prod;
            end
        end
    endtask

    // (r.e)^shininess: x is Q.28 and positive, the result is Q.14 and capped.
    function automatic longint unsigned spec_power(input longint unsigned x);
        int              p;
        longint unsigned f;
        longint unsigned f30;
        longint unsigned k;
        longint unsigned frac;
        longint unsigned mant;
        longint          lg;
        longint          t;
        longint          ip;
        longint          sh;
        p    = top_bit(x);
        f    = x - (64'h1 << p);
        f30  = (p <= 30) ? (f << (30 - p)) : (f >> (p - 30));
        k    = f30 >> FRAC_SH;
        frac = f30 & ((64'h1 << FRAC_SH) - 1);
        lg   = longint'(p - 28) * 65536 + longint'(log2_tab[k])
             + longint'(((log2_tab[k+1] - log2_tab[k]) * frac) >> FRAC_SH);
        t    = (lg * longint'(shine)) >>> 8;
        ip   = t >>> 16;
        f    = longint'(t - ip * 65536);
        k    = f >> EXP_SH;
        frac = f & ((64'h1 << EXP_SH) - 1);
        mant = exp2_tab[k] + (((exp2_tab[k+1] - exp2_tab[k]) * frac) >> EXP_SH);
        if (ip > 20)
            return FACTOR_CAP;
        sh = ip - 16;
        if (sh >= 0)
        begin
            mant = mant << sh;
            return (mant > FACTOR_CAP) ? FACTOR_CAP : mant;
        end
        if (-sh >= 63)
            return 0;
        return mant >> (-sh);
    endfunction

    // Expected shaded color of one hit under the current register copy.
    function automatic color_t shade_hit(input hit_t h);
        longint          d [3];
        longint          nv [3];
        longint          ev [3];
        longint          lv [3];
        longint          rv [3];
        longint          pt [3];
        longint          ndl;
        longint          ndl14;
        longint          rde;
        longint unsigned mag [3];
        longint unsigned mx;
        longint unsigned s;
        longint unsigned q;
        longint unsigned rinv;
        longint unsigned u;
        longint unsigned factor;
        longint unsigned ka;
        longint unsigned kd;
        longint unsigned ks;
        longint unsigned mc;
        longint unsigned ic;
        longint unsigned eff;
        longint unsigned sum;
        longint unsigned chan [3];
        logic [1:0]      terms;
        int              p;
        color_t          c;
        pt[0] = longint'(h.point_x);
        pt[1] = longint'(h.point_y);
        pt[2] = longint'(h.point_z);
        nv[0] = longint'(h.normal_x);
        nv[1] = longint'(h.normal_y);
        nv[2] = longint'(h.normal_z);
        ev[0] = longint'(h.eye_x);
        ev[1] = longint'(h.eye_y);
        ev[2] = longint'(h.eye_z);
        ka = mat_factors[47:32];
        kd = mat_factors[31:16];
        ks = mat_factors[15:0];
        mx = 0;
        s = 0;
        ndl = 0;
        ndl14 = 0;
        rde = 0;
        factor = 0;
        terms = TERMS_AMBIENT;
        for (int i = 0; i < 3; i++)
        begin
            d[i]   = longint'(light_pos[i]) - pt[i];
            mag[i] = (d[i] < 0) ? -d[i] : d[i];
            if (mag[i] > mx)
                mx = mag[i];
        end
        // A zero-length light vector or a shadowed point leaves only ambient light.
        if (mx != 0 && !h.shadowed)
        begin
            p = top_bit(mx);
            for (int i = 0; i < 3; i++)
            begin
                mag[i] = (p > 14) ? (mag[i] >> (p - 14)) : (mag[i] << (14 - p));
                s += mag[i] * mag[i];
            end
            q    = int_sqrt(s << 20);
            rinv = (64'h1 << 48) / q;
            for (int i = 0; i < 3; i++)
            begin
                u     = (mag[i] * rinv + (64'h1 << 23)) >> 24;
                lv[i] = (d[i] < 0) ? -longint'(u) : longint'(u);
                ndl  += lv[i] * nv[i];
            end
            if (ndl >= 0)
            begin
                terms = TERMS_DIFFUSE;
                ndl14 = ndl >>> 14;
                for (int i = 0; i < 3; i++)
                begin
                    rv[i] = -lv[i] + ((2 * ndl14 * nv[i]) >>> 14);
                    rde  += rv[i] * ev[i];
                end
                if (rde > 0)
                begin
                    terms  = TERMS_ALL;
                    factor = spec_power(rde);
                end
            end
            else
                ndl14 = 0;
        end
        for (int i = 0; i < 3; i++)
        begin
            mc  = (mat_color >> (32 - 16 * i)) & 16'hFFFF;
            ic  = (intensity >> (32 - 16 * i)) & 16'hFFFF;
            eff = (mc * ic) >> 14;
            sum = (eff * ka) >> 14;
            if (terms != TERMS_AMBIENT)
                sum += (eff * ((kd * longint'(ndl14)) >> 14)) >> 14;
            if (terms == TERMS_ALL)
                sum += (ic * ((ks * factor) >> 14)) >> 14;
            chan[i] = (sum > 16'hFFFF) ? 16'hFFFF : sum;
        end
        c.red        = chan[0][15:0];
        c.green      = chan[1][15:0];
        c.blue       = chan[2][15:0];
        c.terms_used = terms;
        return c;
    endfunction

    function automatic void note_reg_write(input logic [2:0] idx, input logic [47:0] v);
        case (reg_index_t'(idx))
            REG_MATERIAL_COLOR:   mat_color = v;
            REG_MATERIAL_FACTORS: mat_factors = v;
            REG_SHININESS:        shine = v[15:0];
            REG_LIGHT_INTENSITY:  intensity = v;
            REG_LIGHT_X:          light_pos[0] = v[31:0];
            REG_LIGHT_Y:          light_pos[1] = v[31:0];
            REG_LIGHT_Z:          light_pos[2] = v[31:0];
            default:              ;
        endcase
    endfunction

    function automatic hit_t make_hit(input logic [31:0] px, input logic [31:0] py,
                                      input logic [31:0] pz, input logic [15:0] nx,
                                      input logic [15:0] ny, input logic [15:0] nz,
                                      input logic [15:0] ex, input logic [15:0] ey,
                                      input logic [15:0] ez, input logic sh);
        hit_t h;
        h.point_x  = px;
        h.point_y  = py;
        h.point_z  = pz;
        h.normal_x = nx;
        h.normal_y = ny;
        h.normal_z = nz;
        h.eye_x    = ex;
        h.eye_y    = ey;
        h.eye_z    = ez;
        h.shadowed = sh;
        return h;
    endfunction

    function automatic logic [15:0] to_q14(input real v);
        return 16'($rtoi(v * 16384.0));
    endfunction

    // Random hit. A shaped hit has a unit normal facing the light and a unit eye vector
    // on the reflected side, so that most of them reach the specular path; the rest are
    // raw bit patterns over the whole field ranges.
    function automatic hit_t random_hit(input bit shaped);
        hit_t h;
        real  dv [3];
        real  nr [3];
        real  er [3];
        real  ll [3];
        real  rr [3];
        real  len;
        real  dot;
        if (!shaped)
            return make_hit($urandom, $urandom, $urandom, 16'($urandom), 16'($urandom),
                            16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                            1'($urandom));
        h.point_x  = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
        h.point_y  = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
        h.point_z  = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
        dv[0] = real'(longint'(light_pos[0]) - longint'(h.point_x));
        dv[1] = real'(longint'(light_pos[1]) - longint'(h.point_y));
        dv[2] = real'(longint'(light_pos[2]) - longint'(h.point_z));
        len = $sqrt(dv[0] * dv[0] + dv[1] * dv[1] + dv[2] * dv[2]);
        for (int i = 0; i < 3; i++)
        begin
            ll[i] = (len > 0.0) ? dv[i] / len : 0.0;
            nr[i] = real'($urandom_range(0, 2000)) - 1000.0;
            er[i] = real'($urandom_range(0, 2000)) - 1000.0;
        end
        len = $sqrt(nr[0] * nr[0] + nr[1] * nr[1] + nr[2] * nr[2]) + 1.0e-9;
        dot = 0.0;
        for (int i = 0; i < 3; i++)
        begin
            nr[i] = nr[i] / len;
            dot  += nr[i] * ll[i];
        end
        if (dot < 0.0)
        begin
            for (int i = 0; i < 3; i++)
                nr[i] = -nr[i];
            dot = -dot;
        end
        for (int i = 0; i < 3; i++)
            rr[i] = 2.0 * dot * nr[i] - ll[i];
        // Now and then aim the eye close to the mirror direction for a strong highlight.
        if ($urandom_range(0, 2) == 0)
            for (int i = 0; i < 3; i++)
                er[i] = rr[i] * 1000.0 + er[i] * 0.05;
        len = $sqrt(er[0] * er[0] + er[1] * er[1] + er[2] * er[2]) + 1.0e-9;
        dot = 0.0;
        for (int i = 0; i < 3; i++)
        begin
            er[i] = er[i] / len;
            dot  += er[i] * rr[i];
        end
        if (dot < 0.0 && $urandom_range(0, 3) != 0)
            for (int i = 0; i < 3; i++)
                er[i] = -er[i];
        h.normal_x = to_q14(nr[0] * 0.9999);
        h.normal_y = to_q14(nr[1] * 0.9999);
        h.normal_z = to_q14(nr[2] * 0.9999);
        h.eye_x    = to_q14(er[0] * 0.9999);
        h.eye_y    = to_q14(er[1] * 0.9999);
        h.eye_z    = to_q14(er[2] * 0.9999);
        h.shadowed = ($urandom_range(0, 7) == 0);
        return h;
    endfunction

    // Offers one hit, after a random gap outside burst phases, and waits until the block takes it. Valid is
    // left high after acceptance so that a back-to-back transaction keeps it steady.
    task automatic send_hit(input hit_t h, input bit known, input color_t kc);
        int gap;
        bit taken;
        gap = tx_burst ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            hit_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        hit_valid <= 1'b1;
        hit       <= h;
        do
        begin
            @(negedge clk);
            taken = !hit_stall;
            @(posedge clk);
        end
        while (!taken);
        pending_colors.push_back(known ? kc : shade_hit(h));
    endtask

    // Waits until every expected color has come out and the pipeline has gone quiet.
    task automatic drain_pipeline();
        hit_valid <= 1'b0;
        while (pending_colors.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes all eight register indexes on consecutive cycles; index seven is unmapped.
    task automatic write_registers(input logic [47:0] v [8]);
        for (int idx = 0; idx < 8; idx++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= 3'(idx);
            cfg_data  <= v[idx];
            @(posedge clk);
            note_reg_write(3'(idx), v[idx]);
        end
        cfg_we <= 1'b0;
    endtask

    function automatic logic [47:0] rand_triple(input int hi);
        return {16'($urandom_range(0, hi)), 16'($urandom_range(0, hi)),
                16'($urandom_range(0, hi))};
    endfunction

    // Output side: checks each color transaction and draws the stall that follows it.
    initial
    begin
        int wait_left;
        int long_hold;
        color_t exp_c;
        wait_left = 0;
        long_hold = 0;
        forever
        begin
            @(negedge clk);
            if (color_valid && !color_stall)
            begin
                if (pending_colors.size() == 0)
                begin
                    $display("%0t: unexpected color transaction %h", $time, color);
                    errors++;
                end
                else
                begin
                    exp_c = pending_colors.pop_front();
                    if (color.red !== exp_c.red)
                    begin
                        $display("%0t: red expected %h actual %h", $time, exp_c.red, color.red);
                        errors++;
                    end
                    if (color.green !== exp_c.green)
                    begin
                        $display("%0t: green expected %h actual %h", $time, exp_c.green,
                                 color.green);
                        errors++;
                    end
                    if (color.blue !== exp_c.blue)
                    begin
                        $display("%0t: blue expected %h actual %h", $time, exp_c.blue,
                                 color.blue);
                        errors++;
                    end
                    if (color.terms_used !== exp_c.terms_used)
                    begin
                        $display("%0t: terms_used expected %0d actual %0d", $time,
                                 exp_c.terms_used, color.terms_used);
                        errors++;
                    end
                end
                colors_seen++;
                // One long hold-off lets the pipeline fill up and back-pressure the input.
                if (colors_seen == 700)
                    long_hold = 400;
                wait_left = rx_burst ? 0 : $urandom_range(0, 13);
            end
            @(posedge clk);
            if (long_hold > 0)
            begin
                color_stall <= 1'b1;
                long_hold--;
            end
            else if (wait_left > 0)
            begin
                color_stall <= 1'b1;
                wait_left--;
            end
            else
                color_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        logic [47:0] cfg_vals [8];
        color_t      amb;
        color_t      none_c;
        hit_t        h;
        clk         = 1'b1;
        rst_n       = 1'b0;
        hit_valid   = 1'b0;
        hit         = '0;
        color_stall = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        errors      = 0;
        colors_seen = 0;
        cycles      = 0;
        tx_burst    = 1'b0;
        rx_burst    = 1'b0;
        mat_color    = 48'h4000_4000_4000;
        mat_factors  = 48'h0666_399A_399A;
        shine        = 16'd51200;
        intensity    = 48'h4000_4000_4000;
        light_pos[0] = '0;
        light_pos[1] = '0;
        light_pos[2] = '0;
        fill_tables();

        // With reset registers, ambient alone is 1.0 * 0.1 in Q2.14 on every channel.
        amb.red        = 16'h0666;
        amb.green      = 16'h0666;
        amb.blue       = 16'h0666;
        amb.terms_used = TERMS_AMBIENT;
        none_c = '0;

        // Directed table, walked under the reset registers with the light at the origin.
        rows[0]  = '{make_hit(0, 0, 0, 0, 0, 16'h4000, 0, 0, 16'h4000, 0), 1, amb};
        rows[1]  = '{make_hit(0, 0, -32'sd65536, 0, 0, 16'h4000, 0, 0, 16'h4000, 1), 1, amb};
        rows[2]  = '{make_hit(0, 0, -32'sd65536, 0, 0, 16'h4000, 0, 0, 16'h4000, 0), 0, none_c};
        rows[3]  = '{make_hit(0, 0, -32'sd65536, 0, 0, 16'hC000, 0, 0, 16'h4000, 0), 1, amb};
        rows[4]  = '{make_hit(0, 0, -32'sd65536, 0, 0, 16'h4000, 0, 0, 16'hC000, 0), 0, none_c};
        rows[5]  = '{make_hit(32'h8000_0000, 32'h7FFF_FFFF, 0, 16'h8000, 16'h8000, 16'h8000,
                              16'h7FFF, 16'h7FFF, 16'h7FFF, 0), 0, none_c};
        rows[6]  = '{make_hit(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'h8000, 16'h8000,
                              16'h8000, 16'h8000, 16'h8000, 16'h8000, 0), 0, none_c};
        rows[7]  = '{make_hit(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h7FFF, 16'h7FFF,
                              16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1), 1, amb};
        rows[8]  = '{make_hit(0, 0, -32'sd65536, 0, 0, 16'h4000, 16'h4000, 0, 0, 0), 0, none_c};
        rows[9]  = '{make_hit(0, 0, -32'sd1, 0, 0, 16'h4000, 0, 0, 16'h4000, 0), 0, none_c};
        rows[10] = '{make_hit(0, 0, -32'sd65536, 0, 0, 16'h7FFF, 0, 0, 16'h7FFF, 0), 0, none_c};
        rows[11] = '{make_hit(32'sd65536, 0, -32'sd65536, 0, 0, 16'h4000, 16'hD2BF, 0, 16'h2D41,
                              0), 0, none_c};

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < NUM_ROWS; r++)
            send_hit(rows[r].h, rows[r].known, rows[r].c);
        drain_pipeline();

        // Random phases, each under its own register setting; the pipeline is drained
        // before every write, which also makes the sender wait for all results.
        for (int phase = 1; phase <= NUM_PHASES; phase++)
        begin
            case (phase)
                1:
                begin
                    cfg_vals = '{default: 48'hFFFF_FFFF_FFFF};
                end
                2:
                begin
                    cfg_vals = '{default: 48'h0};
                end
                3:
                begin
                    cfg_vals[0] = rand_triple(16'h8000);
                    cfg_vals[1] = rand_triple(16'h4000);
                    cfg_vals[2] = 48'(16'hFFFF);
                    cfg_vals[3] = rand_triple(16'h8000);
                    cfg_vals[4] = 48'(32'h8000_0000);
                    cfg_vals[5] = 48'(32'h7FFF_FFFF);
                    cfg_vals[6] = 48'(32'h8000_0000);
                    cfg_vals[7] = {16'hFFFF, 32'($urandom)};
                end
                4:
                begin
                    cfg_vals = '{48'h4000_4000_4000, 48'h0666_399A_399A, 48'd51200,
                                 48'h4000_4000_4000, 48'h0, 48'h0, 48'h0, 48'h0};
                end
                default:
                begin
                    cfg_vals[0] = rand_triple(16'h8000);
                    cfg_vals[1] = rand_triple(16'h4000);
                    cfg_vals[2] = 48'($urandom_range(0, 16'h2000));
                    cfg_vals[3] = rand_triple(16'h8000);
                    for (int i = 4; i < 7; i++)
                        cfg_vals[i] = {16'($urandom),
                                       32'($urandom_range(0, 32'h0020_0000) - 32'h0010_0000)};
                    cfg_vals[7] = {16'($urandom), 32'($urandom)};
                end
            endcase
            write_registers(cfg_vals);
            tx_burst = (phase % 3 == 1);
            rx_burst = (phase % 4 == 2);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                h = random_hit($urandom_range(0, 3) != 0);
                send_hit(h, 0, none_c);
            end
            drain_pipeline();
        end

        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
